// ===== design/cre_pkg.sv =====
// ----------------------------------------------------------------------------
// Color ramp evaluator package
// Shared constants, register codes and the segment record passed from the
// classifier to the interpolation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cre_pkg;

  localparam int MaxStops     = 4;
  localparam int NumSlots     = 4;
  localparam int SlotIdxW     = 2;
  localparam int PosW         = 16;
  localparam int ChanW        = 16;
  localparam int NumChan      = 4;
  localparam int ColorW       = ChanW * NumChan;
  localparam int CountW       = 3;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 64;
  localparam int WeightW      = PosW + 1;
  localparam int DivStages    = 4;
  localparam int BitsPerStage = PosW / DivStages;
  localparam int ProdW        = (ChanW + 1) + (WeightW + 1);
  localparam int SumW         = ProdW + 1;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrW    = $clog2(QueueDepth);
  localparam int QueueCntW    = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgStopCount = 3'd0,
    CfgStopTimes = 3'd1,
    CfgColor0    = 3'd2,
    CfgColor1    = 3'd3,
    CfgColor2    = 3'd4,
    CfgColor3    = 3'd5
  } cfg_idx_e;

  typedef logic [NumSlots-1:0][ColorW-1:0] color_set_t;
  typedef logic [NumSlots-1:0][PosW-1:0]   time_set_t;

  typedef struct packed {
    logic [SlotIdxW-1:0] lo;
    logic [SlotIdxW-1:0] hi;
    logic                direct;
    logic                sat;
    logic [PosW-1:0]     num;
    logic [PosW-1:0]     den;
  } seg_t;

endpackage

`default_nettype wire

// ===== design/color_ramp_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// Color ramp evaluator
// Piecewise-linear RGBA gradient lookup over up to four configured stops.
// ----------------------------------------------------------------------------
// The block accepts one ramp position per cycle while the output is not
// stalled and returns one color per position in order. Each position passes
// one classifier register, one queue slot, four divider stages that each
// resolve four weight bits, one multiply stage and the output register. The
// sustained rate of one item per cycle is set by the pipelined restoring
// divider; the four-entry queue lets the classifier keep accepting while the
// output waits. Configuration is always accepted (cfg_ready_o is tied high)
// and is expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module color_ramp_evaluator_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [cre_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cre_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [15:0]                  s_axis_tdata,  // age_fraction
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [63:0]                       m_axis_tdata   // red_out, green_out,
                                                           // blue_out, alpha_out
);

  logic [cre_pkg::CountW-1:0]  stop_count_q;
  cre_pkg::time_set_t          stop_times_q;
  cre_pkg::color_set_t         colors_q;
  logic                        cfg_fire_w;
  logic                        fq_valid_w, fq_ready_w;
  cre_pkg::seg_t               fq_data_w;
  logic                        qb_valid_w, qb_ready_w;
  cre_pkg::seg_t               qb_data_w;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire_w  = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= cre_pkg::CountW'(1);
      stop_times_q <= '0;
      colors_q     <= '0;
    end else if (cfg_fire_w) begin
      unique case (cre_pkg::cfg_idx_e'(cfg_index_i))
        cre_pkg::CfgStopCount: stop_count_q <= cfg_data_i[cre_pkg::CountW-1:0];
        cre_pkg::CfgStopTimes: stop_times_q <= cfg_data_i;
        cre_pkg::CfgColor0:    colors_q[0]  <= cfg_data_i;
        cre_pkg::CfgColor1:    colors_q[1]  <= cfg_data_i;
        cre_pkg::CfgColor2:    colors_q[2]  <= cfg_data_i;
        cre_pkg::CfgColor3:    colors_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cre_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stop_count_i (stop_count_q),
    .stop_times_i (stop_times_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_pos_i     (s_axis_tdata),
    .seg_valid_o  (fq_valid_w),
    .seg_ready_i  (fq_ready_w),
    .seg_o        (fq_data_w)
  );

  cre_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid_w),
    .push_ready_o (fq_ready_w),
    .push_data_i  (fq_data_w),
    .pop_valid_o  (qb_valid_w),
    .pop_ready_i  (qb_ready_w),
    .pop_data_o   (qb_data_w)
  );

  cre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .colors_i    (colors_q),
    .seg_valid_i (qb_valid_w),
    .seg_ready_o (qb_ready_w),
    .seg_i       (qb_data_w),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== design/cre_front.sv =====
// ----------------------------------------------------------------------------
// Color ramp classifier
// Accepts a ramp position, finds its segment and registers the segment
// record together with the weight numerator and denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module cre_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [cre_pkg::CountW-1:0] stop_count_i,
  input  wire cre_pkg::time_set_t         stop_times_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [cre_pkg::PosW-1:0]   in_pos_i,
  output logic                            seg_valid_o,
  input  wire logic                       seg_ready_i,
  output cre_pkg::seg_t                   seg_o
);

  logic                            fv_q, fv_d;
  cre_pkg::seg_t                   seg_q, seg_d;
  logic [cre_pkg::CountW-1:0]      n_w;
  logic [cre_pkg::MaxStops-1:0]    le_w;
  logic                            found_w;
  logic [cre_pkg::SlotIdxW-1:0]    sel_w;
  logic [cre_pkg::PosW-1:0]        a_w, b_w;
  logic                            fire_w;

  always_comb begin
    if (stop_count_i > cre_pkg::CountW'(cre_pkg::MaxStops)) begin
      n_w = cre_pkg::CountW'(cre_pkg::MaxStops);
    end else if (stop_count_i == '0) begin
      n_w = cre_pkg::CountW'(1);
    end else begin
      n_w = stop_count_i;
    end
  end

  always_comb begin
    found_w = 1'b0;
    sel_w   = '0;
    for (int k = 0; k < cre_pkg::MaxStops; k++) begin
      le_w[k] = in_pos_i <= stop_times_i[k];
    end
    for (int i = 1; i < cre_pkg::MaxStops; i++) begin
      if (!found_w && (cre_pkg::CountW'(i) < n_w) && le_w[i]) begin
        found_w = 1'b1;
        sel_w   = cre_pkg::SlotIdxW'(i);
      end
    end
  end

  always_comb begin
    a_w          = stop_times_i[sel_w - cre_pkg::SlotIdxW'(1)];
    b_w          = stop_times_i[sel_w];
    seg_d.num    = '0;
    seg_d.den    = cre_pkg::PosW'(1);
    seg_d.sat    = 1'b0;
    seg_d.direct = 1'b1;
    if (le_w[0]) begin
      seg_d.lo = '0;
      seg_d.hi = '0;
    end else if (found_w) begin
      seg_d.lo     = sel_w - cre_pkg::SlotIdxW'(1);
      seg_d.hi     = sel_w;
      seg_d.direct = 1'b0;
      seg_d.num    = in_pos_i - a_w;
      if (b_w > a_w) begin
        seg_d.den = b_w - a_w;
      end
      seg_d.sat = seg_d.num >= seg_d.den;
    end else begin
      seg_d.lo = cre_pkg::SlotIdxW'(n_w - cre_pkg::CountW'(1));
      seg_d.hi = cre_pkg::SlotIdxW'(n_w - cre_pkg::CountW'(1));
    end
  end

  assign in_ready_o  = !fv_q || seg_ready_i;
  assign fire_w      = in_valid_i && in_ready_o;
  assign fv_d        = fire_w ? 1'b1 : (seg_ready_i ? 1'b0 : fv_q);
  assign seg_valid_o = fv_q;
  assign seg_o       = seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_w) begin
      seg_q <= seg_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/cre_queue.sv =====
// ----------------------------------------------------------------------------
// Color ramp segment queue
// Short first-in first-out buffer between the classifier and the
// interpolation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cre_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire cre_pkg::seg_t push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output cre_pkg::seg_t      pop_data_o
);

  cre_pkg::seg_t                   mem_q [cre_pkg::QueueDepth];
  logic [cre_pkg::QueuePtrW-1:0]   wr_q, rd_q;
  logic [cre_pkg::QueueCntW-1:0]   cnt_q;
  logic                            push_w, pop_w;

  assign push_ready_o = cnt_q != cre_pkg::QueueCntW'(cre_pkg::QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push_w       = push_valid_i && push_ready_o;
  assign pop_w        = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_w) begin
        wr_q <= wr_q + cre_pkg::QueuePtrW'(1);
      end
      if (pop_w) begin
        rd_q <= rd_q + cre_pkg::QueuePtrW'(1);
      end
      if (push_w && !pop_w) begin
        cnt_q <= cnt_q + cre_pkg::QueueCntW'(1);
      end else if (pop_w && !push_w) begin
        cnt_q <= cnt_q - cre_pkg::QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_w) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cre_pkg::QueueCntW'(cre_pkg::QueueDepth))
    else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

// ===== design/cre_back.sv =====
// ----------------------------------------------------------------------------
// Color ramp interpolation pipeline
// Pipelined restoring divider for the weight, one signed multiply per
// channel, rounding and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cre_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cre_pkg::color_set_t         colors_i,
  input  wire logic                        seg_valid_i,
  output logic                             seg_ready_o,
  input  wire cre_pkg::seg_t               seg_i,
  output logic                             m_tvalid_o,
  input  wire logic                        m_tready_i,
  output logic [cre_pkg::ColorW-1:0]       m_tdata_o
);

  localparam int Last = cre_pkg::DivStages - 1;

  typedef struct packed {
    logic                          direct;
    logic                          sat;
    logic [cre_pkg::SlotIdxW-1:0]  hi;
    logic [cre_pkg::PosW-1:0]      rem;
    logic [cre_pkg::PosW-1:0]      quo;
    logic [cre_pkg::PosW-1:0]      den;
    logic [cre_pkg::ColorW-1:0]    ca;
    logic [cre_pkg::ColorW-1:0]    cb;
  } div_t;

  function automatic div_t div_step(div_t x);
    div_t               y;
    logic [cre_pkg::PosW:0] r2;
    y = x;
    for (int k = 0; k < cre_pkg::BitsPerStage; k++) begin
      r2 = {y.rem, 1'b0};
      if (r2 >= {1'b0, y.den}) begin
        y.rem = cre_pkg::PosW'(r2 - {1'b0, y.den});
        y.quo = {y.quo[cre_pkg::PosW-2:0], 1'b1};
      end else begin
        y.rem = r2[cre_pkg::PosW-1:0];
        y.quo = {y.quo[cre_pkg::PosW-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  logic                              adv_w;
  logic [cre_pkg::DivStages-1:0]     dv_q;
  div_t                              d_q  [cre_pkg::DivStages];
  div_t                              din_w[cre_pkg::DivStages];
  logic [cre_pkg::WeightW-1:0]       w_w;
  logic                              mv_q;
  logic signed [cre_pkg::ProdW-1:0]  prod_d[cre_pkg::NumChan];
  logic signed [cre_pkg::ProdW-1:0]  prod_q[cre_pkg::NumChan];
  logic [cre_pkg::ColorW-1:0]        ca_q;
  logic                              ov_q;
  logic [cre_pkg::ColorW-1:0]        out_d, out_q;

  assign adv_w       = !ov_q || m_tready_i;
  assign seg_ready_o = adv_w;
  assign m_tvalid_o  = ov_q;
  assign m_tdata_o   = out_q;

  always_comb begin
    din_w[0].direct = seg_i.direct;
    din_w[0].sat    = seg_i.sat;
    din_w[0].hi     = seg_i.hi;
    din_w[0].rem    = seg_i.sat ? '0 : seg_i.num;
    din_w[0].quo    = '0;
    din_w[0].den    = seg_i.den;
    din_w[0].ca     = colors_i[seg_i.lo];
    din_w[0].cb     = '0;
    din_w[1]        = d_q[0];
    din_w[1].cb     = colors_i[d_q[0].hi];
    for (int k = 2; k < cre_pkg::DivStages; k++) begin
      din_w[k] = d_q[k-1];
    end
  end

  always_comb begin
    if (d_q[Last].direct) begin
      w_w = '0;
    end else if (d_q[Last].sat) begin
      w_w = cre_pkg::WeightW'(1) << cre_pkg::PosW;
    end else begin
      w_w = {1'b0, d_q[Last].quo};
    end
    for (int c = 0; c < cre_pkg::NumChan; c++) begin
      prod_d[c] = cre_pkg::ProdW'(
        $signed({1'b0, d_q[Last].cb[c*cre_pkg::ChanW +: cre_pkg::ChanW]}
              - {1'b0, d_q[Last].ca[c*cre_pkg::ChanW +: cre_pkg::ChanW]})
        * $signed({1'b0, w_w}));
    end
  end

  always_comb begin
    logic signed [cre_pkg::SumW-1:0] sum;
    for (int c = 0; c < cre_pkg::NumChan; c++) begin
      sum = $signed({2'b00, ca_q[c*cre_pkg::ChanW +: cre_pkg::ChanW], {cre_pkg::PosW{1'b0}}})
          + cre_pkg::SumW'(prod_q[c])
          + $signed(cre_pkg::SumW'(1) << (cre_pkg::PosW - 1));
      out_d[c*cre_pkg::ChanW +: cre_pkg::ChanW] = sum[cre_pkg::PosW +: cre_pkg::ChanW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
      mv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv_w) begin
      dv_q <= {dv_q[cre_pkg::DivStages-2:0], seg_valid_i};
      mv_q <= dv_q[Last];
      ov_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      for (int k = 0; k < cre_pkg::DivStages; k++) begin
        d_q[k] <= div_step(din_w[k]);
      end
      for (int c = 0; c < cre_pkg::NumChan; c++) begin
        prod_q[c] <= prod_d[c];
      end
      ca_q  <= d_q[Last].ca;
      out_q <= out_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[Last] |-> (d_q[Last].rem < d_q[Last].den))
    else $error("divider remainder not below denominator");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[0] |-> !(d_q[0].sat && d_q[0].direct))
    else $error("segment both saturated and direct");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_q && !adv_w) |=> (mv_q && $stable(ca_q)))
    else $error("multiply stage changed while stalled");

endmodule

`default_nettype wire
